// ----- hw/rtl/sgp_pkg.sv -----
// Shared types and constants for the SOCKS5 greeting/request parser.
package sgp_pkg;

  // Protocol constants
  localparam logic [7:0] SOCKS_VER     = 8'h05;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN   = 8'h03;
  localparam logic [7:0] METHOD_NONE   = 8'h00;
  localparam logic [7:0] METHOD_REFUSE = 8'hFF;
  localparam logic [9:0] IPV4_REQ_LEN  = 10'd10;

  // Input beat kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Verdict codes
  localparam logic [1:0] VD_OK       = 2'd0;
  localparam logic [1:0] VD_MALFORM  = 2'd1;
  localparam logic [1:0] VD_BAD_LEN  = 2'd2;
  localparam logic [1:0] VD_BAD_ATYP = 2'd3;

  typedef enum logic [1:0] {
    RK_GREET   = 2'd0,
    RK_VERDICT = 2'd1,
    RK_NAME    = 2'd2
  } rkind_e;

  // Session phase, one-hot
  typedef enum logic [2:0] {
    PH_GREET = 3'b001,
    PH_REQ   = 3'b010,
    PH_DONE  = 3'b100
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    rkind_e      result_kind;
    logic [7:0]  reply_method;
    logic [1:0]  verdict;
    logic [7:0]  address_kind;
    logic [31:0] ipv4_addr;
    logic [15:0] dest_port;
    logic [7:0]  name_len;
    logic [7:0]  name_byte;
    logic        session_closed;
  } result_t;

endpackage

// ----- hw/rtl/sgp_in_reg.sv -----
// Input register stage: captures one byte beat and holds it until the core consumes it.
module sgp_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sgp_pkg::item_t item_i,
  input  logic          take_i,
  output logic          valid_o,
  output sgp_pkg::item_t item_o
);

  logic           valid_q;
  sgp_pkg::item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- hw/rtl/sgp_core.sv -----
// Parser core: session state and the single-pass decode of one byte beat.
module sgp_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  sgp_pkg::item_t   item_i,
  output logic             res_valid_o,
  output sgp_pkg::result_t res_o
);

  sgp_pkg::phase_e phase_q, phase_d;
  logic [8:0]  idx_q, idx_d;
  logic [7:0]  mcount_q, mcount_d;
  logic        noauth_q, noauth_d;
  logic        hbad_q, hbad_d;
  logic [7:0]  atyp_q, atyp_d;
  logic [7:0]  dlen_q, dlen_d;
  logic [31:0] addr_q, addr_d;
  logic [15:0] port_q, port_d;

  logic [7:0]  b;
  logic [8:0]  idx_inc;
  logic [9:0]  len;
  logic [9:0]  port_start;
  logic        addr_known;
  logic        name_pos;
  logic        bad;
  logic        hit;
  logic [1:0]  vd;
  logic [7:0]  meth;

  assign b       = item_i.data_byte;
  assign idx_inc = (idx_q == 9'd511) ? idx_q : idx_q + 9'd1;
  assign len     = {1'b0, idx_q} + 10'd1;
  assign port_start = (atyp_q == sgp_pkg::ATYP_IPV4) ? 10'd8 : 10'd5 + {2'b00, dlen_q};
  assign addr_known = (idx_q > 9'd3) &&
                      ((atyp_q == sgp_pkg::ATYP_IPV4) || (atyp_q == sgp_pkg::ATYP_DOMAIN));

  // Next state and result for the current beat
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    mcount_d = mcount_q;
    noauth_d = noauth_q;
    hbad_d   = hbad_q;
    atyp_d   = atyp_q;
    dlen_d   = dlen_q;
    addr_d   = addr_q;
    port_d   = port_q;
    name_pos = 1'b0;
    bad      = 1'b0;
    hit      = 1'b0;
    vd       = sgp_pkg::VD_OK;
    meth     = sgp_pkg::METHOD_REFUSE;
    res_o    = '0;

    if (item_i.kind == sgp_pkg::KIND_RESTART) begin
      phase_d  = sgp_pkg::PH_GREET;
      idx_d    = '0;
      mcount_d = '0;
      noauth_d = 1'b0;
      hbad_d   = 1'b0;
      atyp_d   = '0;
      dlen_d   = '0;
      addr_d   = '0;
      port_d   = '0;
    end else if (phase_q == sgp_pkg::PH_GREET) begin
      // Greeting: version, method count, method list
      if (idx_q == 9'd0) begin
        if (b != sgp_pkg::SOCKS_VER) hbad_d = 1'b1;
      end else if (idx_q == 9'd1) begin
        mcount_d = b;
      end else if (((idx_q - 9'd2) < {1'b0, mcount_q}) && (b == sgp_pkg::METHOD_NONE)) begin
        noauth_d = 1'b1;
      end
      if (!item_i.last_byte) begin
        idx_d = idx_inc;
      end else begin
        bad  = hbad_d || (idx_q < 9'd2);
        meth = (!bad && noauth_d) ? sgp_pkg::METHOD_NONE : sgp_pkg::METHOD_REFUSE;
        hit  = 1'b1;
        res_o.result_kind    = sgp_pkg::RK_GREET;
        res_o.reply_method   = meth;
        res_o.verdict        = bad ? sgp_pkg::VD_MALFORM : sgp_pkg::VD_OK;
        res_o.session_closed = (meth == sgp_pkg::METHOD_REFUSE);
        phase_d  = (meth == sgp_pkg::METHOD_REFUSE) ? sgp_pkg::PH_DONE : sgp_pkg::PH_REQ;
        idx_d    = '0;
        mcount_d = '0;
        noauth_d = 1'b0;
        hbad_d   = 1'b0;
        atyp_d   = '0;
        dlen_d   = '0;
        addr_d   = '0;
        port_d   = '0;
      end
    end else if (phase_q == sgp_pkg::PH_REQ) begin
      // Request header and address fields
      if (idx_q == 9'd0) begin
        if (b != sgp_pkg::SOCKS_VER) hbad_d = 1'b1;
      end else if (idx_q == 9'd1) begin
        if (b != sgp_pkg::CMD_CONNECT) hbad_d = 1'b1;
      end else if (idx_q == 9'd3) begin
        atyp_d = b;
      end else if (addr_known) begin
        if ((atyp_q == sgp_pkg::ATYP_IPV4) && (idx_q <= 9'd7)) begin
          addr_d = {addr_q[23:0], b};
        end else if ((atyp_q == sgp_pkg::ATYP_DOMAIN) && (idx_q == 9'd4)) begin
          dlen_d = b;
        end else if ((atyp_q == sgp_pkg::ATYP_DOMAIN) && ({1'b0, idx_q} < port_start)) begin
          name_pos = 1'b1;
        end else if (({1'b0, idx_q} == port_start) ||
                     ({1'b0, idx_q} == port_start + 10'd1)) begin
          port_d = {port_q[7:0], b};
        end
      end
      if (!item_i.last_byte) begin
        idx_d = idx_inc;
        if (name_pos && !hbad_d) begin
          hit = 1'b1;
          res_o.result_kind  = sgp_pkg::RK_NAME;
          res_o.address_kind = sgp_pkg::ATYP_DOMAIN;
          res_o.name_len     = dlen_q;
          res_o.name_byte    = b;
        end
      end else begin
        if (hbad_d || (len < 10'd5)) begin
          vd = sgp_pkg::VD_MALFORM;
        end else if (atyp_d == sgp_pkg::ATYP_IPV4) begin
          vd = (len != sgp_pkg::IPV4_REQ_LEN) ? sgp_pkg::VD_BAD_LEN : sgp_pkg::VD_OK;
        end else if (atyp_d == sgp_pkg::ATYP_DOMAIN) begin
          vd = (len != 10'd7 + {2'b00, dlen_d}) ? sgp_pkg::VD_BAD_LEN : sgp_pkg::VD_OK;
        end else begin
          vd = sgp_pkg::VD_BAD_ATYP;
        end
        hit = 1'b1;
        res_o.result_kind  = sgp_pkg::RK_VERDICT;
        res_o.verdict      = vd;
        res_o.address_kind = atyp_d;
        if (vd == sgp_pkg::VD_OK) begin
          if (atyp_d == sgp_pkg::ATYP_IPV4) begin
            res_o.ipv4_addr = addr_d;
          end else begin
            res_o.name_len = dlen_d;
          end
          res_o.dest_port = port_d;
        end
        res_o.session_closed = (vd != sgp_pkg::VD_OK);
        phase_d  = sgp_pkg::PH_DONE;
        idx_d    = '0;
        mcount_d = '0;
        noauth_d = 1'b0;
        hbad_d   = 1'b0;
        atyp_d   = '0;
        dlen_d   = '0;
        addr_d   = '0;
        port_d   = '0;
      end
    end
    // finished session: bytes ignored until restart
  end

  assign res_valid_o = step_i && hit;

  // Session state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= sgp_pkg::PH_GREET;
      idx_q    <= '0;
      mcount_q <= '0;
      noauth_q <= 1'b0;
      hbad_q   <= 1'b0;
      atyp_q   <= '0;
      dlen_q   <= '0;
      addr_q   <= '0;
      port_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      mcount_q <= mcount_d;
      noauth_q <= noauth_d;
      hbad_q   <= hbad_d;
      atyp_q   <= atyp_d;
      dlen_q   <= dlen_d;
      addr_q   <= addr_d;
      port_q   <= port_d;
    end
  end

  // Checks
  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q)) else $error("phase register not one-hot");

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == sgp_pkg::PH_DONE) |-> !res_valid_o)
    else $error("result produced in finished session");

  a_verdict_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.result_kind == sgp_pkg::RK_VERDICT)) |=>
    (phase_q == sgp_pkg::PH_DONE && idx_q == 9'd0))
    else $error("verdict did not finish the session");

  a_name_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.result_kind == sgp_pkg::RK_NAME)) |->
    (!res_o.session_closed && phase_q == sgp_pkg::PH_REQ))
    else $error("name byte outside open request");

endmodule

// ----- hw/rtl/sgp_out_reg.sv -----
// Result register: holds one result beat until the consumer takes it.
module sgp_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  logic             res_valid_i,
  input  sgp_pkg::result_t res_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sgp_pkg::result_t res_o
);

  logic             valid_q;
  sgp_pkg::result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- hw/rtl/socks5_greeting_request_parser.sv -----
// SOCKS5 greeting/request parser top level.
// A byte beat is held in the input register until the result register is free; then
//   its result is registered there. Beats with no result leave nothing.
// Throughput: one byte beat per cycle while the result register is free.
// Reset: rst_ni clears the session to awaiting greeting and empties both registers.
module socks5_greeting_request_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  reply_method_o,
  output logic [1:0]  verdict_o,
  output logic [7:0]  address_kind_o,
  output logic [31:0] ipv4_addr_o,
  output logic [15:0] dest_port_o,
  output logic [7:0]  name_len_o,
  output logic [7:0]  name_byte_o,
  output logic        session_closed_o
);

  sgp_pkg::item_t   in_item;
  sgp_pkg::item_t   item_q;
  logic             item_valid;
  logic             out_free;
  logic             step;
  logic             res_valid;
  sgp_pkg::result_t res;
  sgp_pkg::result_t res_q;

  assign in_item.kind      = kind_i;
  assign in_item.data_byte = data_byte_i;
  assign in_item.last_byte = last_byte_i;

  // Core advances when a beat is held and the result slot can take it
  assign step = item_valid && out_free;

  sgp_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (step),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  sgp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sgp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_q)
  );

  assign result_kind_o    = res_q.result_kind;
  assign reply_method_o   = res_q.reply_method;
  assign verdict_o        = res_q.verdict;
  assign address_kind_o   = res_q.address_kind;
  assign ipv4_addr_o      = res_q.ipv4_addr;
  assign dest_port_o      = res_q.dest_port;
  assign name_len_o       = res_q.name_len;
  assign name_byte_o      = res_q.name_byte;
  assign session_closed_o = res_q.session_closed;

endmodule

// ----- dv/socks5_greeting_request_parser_tb.sv -----
// Testbench for the SOCKS5 greeting/request parser: random sessions, self-checking.
`timescale 1ns / 1ps

module socks5_greeting_request_parser_tb;

  typedef enum logic [1:0] {
    SESS_GREET = 2'd0,
    SESS_REQ   = 2'd1,
    SESS_DONE  = 2'd2
  } sess_e;

  // Session tracker: predicts replies, verdicts and name bytes, then checks them
  class handshake_scoreboard;
    sgp_pkg::result_t expected[$];
    int          fails;
    sess_e       sess;
    logic [8:0]  byte_idx;
    logic [7:0]  n_methods;
    bit          no_auth;
    bit          hdr_bad;
    logic [7:0]  atyp;
    logic [7:0]  dom_len;
    logic [31:0] addr_acc;
    logic [15:0] port_acc;

    function new();
      fails = 0;
      sess  = SESS_GREET;
      clear_message();
    endfunction

    function void clear_message();
      byte_idx  = '0;
      n_methods = '0;
      no_auth   = 1'b0;
      hdr_bad   = 1'b0;
      atyp      = '0;
      dom_len   = '0;
      addr_acc  = '0;
      port_acc  = '0;
    endfunction

    // Index saturates so an overlong message never wraps back to a valid length
    function void advance();
      if (byte_idx < 9'd511) byte_idx++;
    endfunction

    // Takes one accepted beat; returns 0 when the session ignores it
    function bit note_beat(logic k, logic [7:0] b, logic is_last);
      sgp_pkg::result_t r;
      int         idx;
      int         len;
      int         port_start;
      bit         addr_known;
      bit         name_pos;
      bit         bad;
      logic [1:0] vd;
      r = '0;
      if (k == sgp_pkg::KIND_RESTART) begin
        sess = SESS_GREET;
        clear_message();
        return 1'b1;
      end
      if (sess == SESS_DONE) return 1'b0;
      idx = int'(byte_idx);
      len = idx + 1;

      // Greeting: version, method count, method list
      if (sess == SESS_GREET) begin
        if (idx == 0) begin
          if (b != sgp_pkg::SOCKS_VER) hdr_bad = 1'b1;
        end else if (idx == 1) begin
          n_methods = b;
        end else if ((idx - 2) < int'(n_methods) && b == sgp_pkg::METHOD_NONE) begin
          no_auth = 1'b1;
        end
        if (!is_last) begin
          advance();
          return 1'b1;
        end
        bad = hdr_bad || len < 3;
        r.result_kind    = sgp_pkg::RK_GREET;
        r.reply_method   = (!bad && no_auth) ? sgp_pkg::METHOD_NONE : sgp_pkg::METHOD_REFUSE;
        r.verdict        = bad ? sgp_pkg::VD_MALFORM : sgp_pkg::VD_OK;
        r.session_closed = (r.reply_method == sgp_pkg::METHOD_REFUSE);
        sess = r.session_closed ? SESS_DONE : SESS_REQ;
        clear_message();
        expected.push_back(r);
        return 1'b1;
      end

      // Request: header, address, port
      port_start = (atyp == sgp_pkg::ATYP_IPV4) ? 8 : 5 + int'(dom_len);
      addr_known = idx > 3 && (atyp == sgp_pkg::ATYP_IPV4 || atyp == sgp_pkg::ATYP_DOMAIN);
      name_pos   = 1'b0;
      if (idx == 0) begin
        if (b != sgp_pkg::SOCKS_VER) hdr_bad = 1'b1;
      end else if (idx == 1) begin
        if (b != sgp_pkg::CMD_CONNECT) hdr_bad = 1'b1;
      end else if (idx == 3) begin
        atyp = b;
      end else if (addr_known) begin
        if (atyp == sgp_pkg::ATYP_IPV4 && idx >= 4 && idx <= 7) begin
          addr_acc = {addr_acc[23:0], b};
        end else if (atyp == sgp_pkg::ATYP_DOMAIN && idx == 4) begin
          dom_len = b;
        end else if (atyp == sgp_pkg::ATYP_DOMAIN && idx < port_start) begin
          name_pos = 1'b1;
        end else if (idx == port_start || idx == port_start + 1) begin
          port_acc = {port_acc[7:0], b};
        end
      end
      if (!is_last) begin
        advance();
        if (name_pos && !hdr_bad) begin
          r.result_kind  = sgp_pkg::RK_NAME;
          r.address_kind = sgp_pkg::ATYP_DOMAIN;
          r.name_len     = dom_len;
          r.name_byte    = b;
          expected.push_back(r);
        end
        return 1'b1;
      end
      if (hdr_bad || len < 5) begin
        vd = sgp_pkg::VD_MALFORM;
      end else if (atyp == sgp_pkg::ATYP_IPV4) begin
        vd = (len != int'(sgp_pkg::IPV4_REQ_LEN)) ? sgp_pkg::VD_BAD_LEN : sgp_pkg::VD_OK;
      end else if (atyp == sgp_pkg::ATYP_DOMAIN) begin
        vd = (len != 7 + int'(dom_len)) ? sgp_pkg::VD_BAD_LEN : sgp_pkg::VD_OK;
      end else begin
        vd = sgp_pkg::VD_BAD_ATYP;
      end
      r.result_kind  = sgp_pkg::RK_VERDICT;
      r.verdict      = vd;
      r.address_kind = atyp;
      if (vd == sgp_pkg::VD_OK) begin
        if (atyp == sgp_pkg::ATYP_IPV4) r.ipv4_addr = addr_acc;
        else r.name_len = dom_len;
        r.dest_port = port_acc;
      end
      r.session_closed = (vd != sgp_pkg::VD_OK);
      sess = SESS_DONE;
      clear_message();
      expected.push_back(r);
      return 1'b1;
    endfunction

    function void cmp(string field, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        fails++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
      end
    endfunction

    // Compares one accepted result beat with the oldest expectation
    function void check_result(sgp_pkg::result_t act);
      sgp_pkg::result_t e;
      if (expected.size() == 0) begin
        fails++;
        $display("%0t: unexpected result, expected none actual %0h", $time, act);
        return;
      end
      e = expected.pop_front();
      cmp("result_kind", 32'(e.result_kind), 32'(act.result_kind));
      cmp("reply_method", 32'(e.reply_method), 32'(act.reply_method));
      cmp("verdict", 32'(e.verdict), 32'(act.verdict));
      cmp("address_kind", 32'(e.address_kind), 32'(act.address_kind));
      cmp("ipv4_addr", e.ipv4_addr, act.ipv4_addr);
      cmp("dest_port", 32'(e.dest_port), 32'(act.dest_port));
      cmp("name_len", 32'(e.name_len), 32'(act.name_len));
      cmp("name_byte", 32'(e.name_byte), 32'(act.name_byte));
      cmp("session_closed", 32'(e.session_closed), 32'(act.session_closed));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  result_kind_o;
  logic [7:0]  reply_method_o;
  logic [1:0]  verdict_o;
  logic [7:0]  address_kind_o;
  logic [31:0] ipv4_addr_o;
  logic [15:0] dest_port_o;
  logic [7:0]  name_len_o;
  logic [7:0]  name_byte_o;
  logic        session_closed_o;

  handshake_scoreboard sb;
  logic [7:0]          msg_bytes[$];
  int                  counted_beats;
  bit                  in_no_idle;
  bit                  out_no_idle;
  bit                  long_pending;

  socks5_greeting_request_parser dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_kind_o    (result_kind_o),
    .reply_method_o   (reply_method_o),
    .verdict_o        (verdict_o),
    .address_kind_o   (address_kind_o),
    .ipv4_addr_o      (ipv4_addr_o),
    .dest_port_o      (dest_port_o),
    .name_len_o       (name_len_o),
    .name_byte_o      (name_byte_o),
    .session_closed_o (session_closed_o)
  );

  // 2 ns clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic int idle_cycles(bit no_idle);
    return no_idle ? 0 : $urandom_range(0, 14);
  endfunction

  // Drives one input beat from a falling edge and returns at a falling edge
  task automatic drive_beat(logic k, logic [7:0] b, logic is_last);
    int gap;
    gap = idle_cycles(in_no_idle);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= k;
    data_byte_i <= b;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    counted_beats += int'(sb.note_beat(k, b, is_last));
    @(negedge clk_i);
  endtask

  task automatic send_msg();
    foreach (msg_bytes[i]) begin
      drive_beat(sgp_pkg::KIND_BYTE, msg_bytes[i], i == msg_bytes.size() - 1);
    end
  endtask

  // Occasionally cut a message short or pad it with stray bytes
  task automatic mangle_tail();
    int r;
    int keep;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      keep = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    end else if (r == 1) begin
      repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic build_greeting();
    int n;
    int r;
    msg_bytes = {};
    r = $urandom_range(0, 99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6)) msg_bytes.push_back(8'($urandom));
      return;
    end
    msg_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : sgp_pkg::SOCKS_VER);
    if (r < 12) begin
      // count far beyond the methods actually sent
      msg_bytes.push_back(8'hFF);
      n = $urandom_range(0, 4);
    end else begin
      n = $urandom_range(0, 5);
      msg_bytes.push_back(8'(n));
    end
    repeat (n)
      msg_bytes.push_back(($urandom_range(0, 2) == 0) ? sgp_pkg::METHOD_NONE
                                                       : 8'($urandom_range(1, 255)));
    mangle_tail();
  endtask

  task automatic build_request();
    int         r;
    logic [7:0] dlen;
    msg_bytes = {};
    msg_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : sgp_pkg::SOCKS_VER);
    msg_bytes.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : sgp_pkg::CMD_CONNECT);
    msg_bytes.push_back(8'($urandom));
    r = $urandom_range(0, 19);
    if (r < 9) begin
      msg_bytes.push_back(sgp_pkg::ATYP_IPV4);
      repeat (6) msg_bytes.push_back(8'($urandom));
    end else if (r < 18) begin
      dlen = ($urandom_range(0, 39) == 0) ? 8'hFF : 8'($urandom_range(0, 12));
      msg_bytes.push_back(sgp_pkg::ATYP_DOMAIN);
      msg_bytes.push_back(dlen);
      repeat (dlen) msg_bytes.push_back(8'($urandom));
      repeat (2) msg_bytes.push_back(8'($urandom));
    end else begin
      msg_bytes.push_back(8'($urandom));
      repeat ($urandom_range(0, 8)) msg_bytes.push_back(8'($urandom));
    end
    mangle_tail();
  endtask

  // One session: usually a restart, then greeting, request when allowed, maybe stray bytes
  task automatic run_session(int sess_no);
    if ($urandom_range(0, 9) != 0) begin
      drive_beat(sgp_pkg::KIND_RESTART, 8'($urandom), 1'($urandom));
    end
    in_no_idle = ($urandom_range(0, 3) == 0);
    build_greeting();
    send_msg();
    if (sb.sess == SESS_REQ) begin
      build_request();
      if (long_pending && sess_no >= 15) begin
        repeat (515) msg_bytes.push_back(8'($urandom));
        long_pending = 1'b0;
      end
      send_msg();
    end
    if ($urandom_range(0, 4) == 0) begin
      msg_bytes = {};
      repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom));
      send_msg();
    end
  endtask

  // Stimulus and end of run
  initial begin
    int sess_no;
    in_valid_i    = 1'b0;
    kind_i        = sgp_pkg::KIND_BYTE;
    data_byte_i   = '0;
    last_byte_i   = 1'b0;
    out_ready_i   = 1'b0;
    rst_ni        = 1'b0;
    counted_beats = 0;
    in_no_idle    = 1'b0;
    out_no_idle   = 1'b0;
    long_pending  = 1'b1;
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // greeting too short
    msg_bytes = {sgp_pkg::SOCKS_VER, 8'h00};
    send_msg();
    // closed session ignores bytes
    msg_bytes = {8'hFF};
    send_msg();
    drive_beat(sgp_pkg::KIND_RESTART, 8'h00, 1'b0);
    // no-auth offered only past the method count
    msg_bytes = {sgp_pkg::SOCKS_VER, 8'h01, 8'h01, sgp_pkg::METHOD_NONE};
    send_msg();
    drive_beat(sgp_pkg::KIND_RESTART, 8'hFF, 1'b1);
    // wrong version, single byte
    msg_bytes = {8'hFF};
    send_msg();
    drive_beat(sgp_pkg::KIND_RESTART, 8'h5A, 1'b0);
    // good greeting, then a domain request
    msg_bytes = {sgp_pkg::SOCKS_VER, 8'h01, sgp_pkg::METHOD_NONE};
    send_msg();
    msg_bytes = {sgp_pkg::SOCKS_VER, sgp_pkg::CMD_CONNECT, 8'h00, sgp_pkg::ATYP_DOMAIN,
                 8'h02, 8'h61, 8'hFF, 8'h00, 8'h50};
    send_msg();

    sess_no = 0;
    while (counted_beats < 1350) begin
      run_session(sess_no);
      sess_no++;
    end
    in_valid_i <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Result side: random stalls, sample at the rising edge
  initial begin
    int               stall;
    sgp_pkg::result_t act;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) out_no_idle = !out_no_idle;
      stall = idle_cycles(out_no_idle);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      act.result_kind    = sgp_pkg::rkind_e'(result_kind_o);
      act.reply_method   = reply_method_o;
      act.verdict        = verdict_o;
      act.address_kind   = address_kind_o;
      act.ipv4_addr      = ipv4_addr_o;
      act.dest_port      = dest_port_o;
      act.name_len       = name_len_o;
      act.name_byte      = name_byte_o;
      act.session_closed = session_closed_o;
      sb.check_result(act);
      @(negedge clk_i);
    end
  end

  // Watchdog
  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sgp_pkg.sv
hw/rtl/sgp_in_reg.sv
hw/rtl/sgp_core.sv
hw/rtl/sgp_out_reg.sv
hw/rtl/socks5_greeting_request_parser.sv
dv/socks5_greeting_request_parser_tb.sv
